/* hdl/pmspmv_pkg.sv */
package pmspmv_pkg;

	localparam int VECTOR_DEPTH = 1024;
	localparam int SUM_WIDTH    = 48;

	localparam int DATA_W    = 32;
	localparam int IDX_W     = 10;
	localparam int ROW_W     = 16;
	localparam int FRAC_W    = 16;
	localparam int ADDR_W    = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
	localparam int NDIG      = (SUM_WIDTH + FRAC_W - 1) / FRAC_W;
	localparam int BW        = NDIG * FRAC_W;
	localparam int DIG_SEL_W = $clog2(NDIG);
	localparam int STEP_W    = $clog2(NDIG + 1);
	localparam int PROD_W    = DATA_W + FRAC_W + 1;
	localparam int ACC_W     = DATA_W + BW + 1;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_ENTRY = 2'd1,
		CMD_LAST  = 2'd2,
		CMD_EMPTY = 2'd3
	} command_t;

	typedef enum logic [1:0] {
		REG_MATRIX = 2'd0,
		REG_ALPHA  = 2'd1,
		REG_BETA   = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		PH_P = 2'd0,
		PH_Q = 2'd1,
		PH_R = 2'd2
	} phase_t;

	typedef struct packed {
		logic                 accept;
		logic                 load;
		logic                 acc_en;
		logic                 mul_go;
		logic [DIG_SEL_W-1:0] digit;
		logic                 acc_first;
		logic                 acc_mid;
		logic                 acc_last;
		phase_t               phase;
		logic                 final_en;
	} dp_cmd_t;

endpackage

/* hdl/pmspmv_ram.sv */
module pmspmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/pmspmv_ctrl.sv */
module pmspmv_ctrl import pmspmv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	output logic       out_valid,
	input  logic       out_ready,
	output dp_cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ACC,
		S_MUL,
		S_FINAL
	} state_t;

	state_t              state_q;
	phase_t              phase_q;
	logic [STEP_W-1:0]   step_q;
	logic                finish_q;
	logic                out_valid_q;
	logic                accept;
	logic                out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.accept    = accept;
		cmd.load      = accept && (command == CMD_LOAD);
		cmd.acc_en    = (state_q == S_ACC);
		cmd.phase     = phase_q;
		cmd.mul_go    = (state_q == S_MUL) && (step_q < STEP_W'(NDIG));
		cmd.digit     = DIG_SEL_W'(NDIG - 1) - step_q[DIG_SEL_W-1:0];
		cmd.acc_first = (state_q == S_MUL) && (step_q == STEP_W'(1));
		cmd.acc_mid   = (state_q == S_MUL) && (step_q > STEP_W'(1))
			&& (step_q < STEP_W'(NDIG));
		cmd.acc_last  = (state_q == S_MUL) && (step_q == STEP_W'(NDIG));
		cmd.final_en  = (state_q == S_FINAL) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_P;
			step_q      <= '0;
			finish_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (command)
							CMD_LOAD: begin
							end
							CMD_ENTRY: begin
								state_q  <= S_ACC;
								finish_q <= 1'b0;
							end
							CMD_LAST: begin
								state_q  <= S_ACC;
								finish_q <= 1'b1;
							end
							CMD_EMPTY: begin
								state_q <= S_MUL;
								phase_q <= PH_P;
								step_q  <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_ACC: begin
					if (finish_q) begin
						state_q <= S_MUL;
						phase_q <= PH_P;
						step_q  <= '0;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MUL: begin
					if (step_q == STEP_W'(NDIG)) begin
						step_q <= '0;
						if (phase_q == PH_R) begin
							state_q <= S_FINAL;
						end else begin
							phase_q <= (phase_q == PH_P) ? PH_Q : PH_R;
						end
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_FINAL: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_final_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.final_en |=> out_valid)
		else $error("result register not loaded after finish");

	a_final_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.final_en |-> (!out_valid || out_ready))
		else $error("finish overwrote an unaccepted result");

	a_acc_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ACC |-> $past(accept))
		else $error("accumulate without an accepted entry");

	a_step_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |-> step_q <= STEP_W'(NDIG))
		else $error("multiply step counter out of range");

endmodule

/* hdl/pmspmv_dp.sv */
module pmspmv_dp import pmspmv_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	input  logic [IDX_W-1:0]         index,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [DATA_W-1:0]        cfg_data,
	output logic signed [DATA_W-1:0] row_result,
	output logic [ROW_W-1:0]         row_number,
	output logic                     saturated
);

	logic signed [DATA_W-1:0]    matrix_q;
	logic signed [DATA_W-1:0]    alpha_q;
	logic signed [DATA_W-1:0]    beta_q;
	logic signed [DATA_W-1:0]    value_q;
	logic                        in_range_q;
	logic signed [SUM_WIDTH-1:0] row_sum_q;
	logic                        row_sat_q;
	logic                        fin_sat_q;
	logic [ROW_W-1:0]            row_cnt_q;
	logic signed [PROD_W-1:0]    prod_s1;
	logic signed [ACC_W-1:0]     acc_q;
	logic signed [SUM_WIDTH-1:0] p_q;
	logic signed [SUM_WIDTH-1:0] q_q;
	logic signed [SUM_WIDTH-1:0] r_q;
	logic signed [DATA_W-1:0]    row_result_q;
	logic [ROW_W-1:0]            row_number_q;
	logic                        saturated_q;

	logic                        in_range;
	logic [ADDR_W-1:0]           addr;
	logic [DATA_W-1:0]           vec_rd;
	logic signed [SUM_WIDTH-1:0] addend;
	logic signed [SUM_WIDTH:0]   row_add;
	logic signed [SUM_WIDTH-1:0] row_add_sat;
	logic                        row_add_ovf;
	logic signed [DATA_W-1:0]    a_sel;
	logic signed [BW-1:0]        b_sel;
	logic [FRAC_W-1:0]           digit;
	logic signed [FRAC_W:0]      digit_ext;
	logic signed [PROD_W-1:0]    prod;
	logic signed [ACC_W-1:0]     acc_fin;
	logic signed [SUM_WIDTH-1:0] mul_res;
	logic                        mul_ovf;
	logic signed [SUM_WIDTH:0]   y_sum;
	logic signed [DATA_W-1:0]    y_sat;
	logic                        y_ovf;

	localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
	localparam logic signed [DATA_W-1:0]    OUT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0]    OUT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	assign cfg_ready = 1'b1;
	assign in_range  = (32'(index) < 32'(VECTOR_DEPTH));
	assign addr      = ADDR_W'(index);

	pmspmv_ram #(
		.WIDTH(DATA_W),
		.DEPTH(VECTOR_DEPTH)
	) u_vec_ram (
		.clk   (clk),
		.we    (cmd.load && in_range),
		.waddr (addr),
		.wdata (value),
		.re    (cmd.accept),
		.raddr (addr),
		.rdata (vec_rd)
	);

	always_comb begin
		addend      = in_range_q ? SUM_WIDTH'(signed'(vec_rd)) : '0;
		row_add     = (SUM_WIDTH+1)'(row_sum_q) + (SUM_WIDTH+1)'(addend);
		row_add_ovf = (row_add[SUM_WIDTH] != row_add[SUM_WIDTH-1]);
		row_add_sat = row_add_ovf ? (row_add[SUM_WIDTH] ? SUM_MIN : SUM_MAX)
			: row_add[SUM_WIDTH-1:0];
	end

	always_comb begin
		unique case (cmd.phase)
			PH_P: begin
				a_sel = matrix_q;
				b_sel = BW'(row_sum_q);
			end
			PH_Q: begin
				a_sel = alpha_q;
				b_sel = BW'(p_q);
			end
			PH_R: begin
				a_sel = beta_q;
				b_sel = BW'(value_q);
			end
			default: begin
				a_sel = matrix_q;
				b_sel = BW'(row_sum_q);
			end
		endcase
		digit     = b_sel[cmd.digit*FRAC_W +: FRAC_W];
		digit_ext = (cmd.digit == DIG_SEL_W'(NDIG - 1)) ? {digit[FRAC_W-1], digit}
			: {1'b0, digit};
		prod      = PROD_W'(a_sel) * PROD_W'(digit_ext);
	end

	always_comb begin
		acc_fin = acc_q + ACC_W'(prod_s1 >>> FRAC_W);
		mul_ovf = !((&acc_fin[ACC_W-1:SUM_WIDTH-1]) || !(|acc_fin[ACC_W-1:SUM_WIDTH-1]));
		mul_res = mul_ovf ? (acc_fin[ACC_W-1] ? SUM_MIN : SUM_MAX)
			: acc_fin[SUM_WIDTH-1:0];
	end

	always_comb begin
		y_sum = (SUM_WIDTH+1)'(q_q) + (SUM_WIDTH+1)'(r_q);
		y_ovf = !((&y_sum[SUM_WIDTH:DATA_W-1]) || !(|y_sum[SUM_WIDTH:DATA_W-1]));
		y_sat = y_ovf ? (y_sum[SUM_WIDTH] ? OUT_MIN : OUT_MAX) : y_sum[DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_q  <= 32'sh0001_0000;
			alpha_q   <= 32'sh0001_0000;
			beta_q    <= '0;
			row_sum_q <= '0;
			row_sat_q <= 1'b0;
			fin_sat_q <= 1'b0;
			row_cnt_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_MATRIX: matrix_q <= cfg_data;
					REG_ALPHA:  alpha_q  <= cfg_data;
					REG_BETA:   beta_q   <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.acc_en) begin
				row_sum_q <= row_add_sat;
				row_sat_q <= row_sat_q | row_add_ovf;
			end
			if (cmd.acc_last) begin
				fin_sat_q <= fin_sat_q | mul_ovf;
			end
			priority if (cmd.load) begin
				row_cnt_q <= '0;
			end else if (cmd.final_en) begin
				row_cnt_q <= row_cnt_q + ROW_W'(1);
				row_sum_q <= '0;
				row_sat_q <= 1'b0;
				fin_sat_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			value_q    <= value;
			in_range_q <= in_range;
		end
		if (cmd.mul_go) begin
			prod_s1 <= prod;
		end
		if (cmd.acc_first) begin
			acc_q <= ACC_W'(prod_s1);
		end else if (cmd.acc_mid) begin
			acc_q <= (acc_q <<< FRAC_W) + ACC_W'(prod_s1);
		end
		if (cmd.acc_last) begin
			unique case (cmd.phase)
				PH_P: p_q <= mul_res;
				PH_Q: q_q <= mul_res;
				PH_R: r_q <= mul_res;
				default: begin
				end
			endcase
		end
		if (cmd.final_en) begin
			row_result_q <= y_sat;
			row_number_q <= row_cnt_q;
			saturated_q  <= row_sat_q | fin_sat_q | y_ovf;
		end
	end

	assign row_result = row_result_q;
	assign row_number = row_number_q;
	assign saturated  = saturated_q;

endmodule

/* hdl/pattern_matrix_spmv.sv */
// Load beat writes the vector RAM. Entry beat: vector RAM read, then saturating add.
// Row finish: three scaled products, each taken digit by digit on one 32x17 multiplier
// (NDIG = SUM_WIDTH/16 rounded up), then the final add; result registered.
// One beat in flight at a time; a new beat is taken while a result waits on the output.
// arst_n clears control state, scale registers, row sum, flags and row count; vector RAM is not cleared.
module pattern_matrix_spmv import pmspmv_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               command,
	input  logic [IDX_W-1:0]         index,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] row_result,
	output logic [ROW_W-1:0]         row_number,
	output logic                     saturated,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [DATA_W-1:0]        cfg_data
);

	dp_cmd_t cmd;

	pmspmv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	pmspmv_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.index      (index),
		.value      (value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.row_result (row_result),
		.row_number (row_number),
		.saturated  (saturated)
	);

endmodule
